// File: hdl/dfe_pkg.sv
// Shared types and constants for the delimited field extractor.
// Used by the front, job queue, back and top-level modules.
`default_nettype none
package dfe_pkg;

  // Fixed widths of the data path
  localparam int WIN_W  = 64;  // history window, eight bytes
  localparam int LEN_W  = 6;   // field length and buffer address
  localparam int CMP_W  = 7;   // width used for length compares

  // Result status codes
  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NULL  = 2'd2;
  localparam logic [1:0] ST_LONG  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_START_PAT = 3'd0;
  localparam logic [2:0] REG_START_LEN = 3'd1;
  localparam logic [2:0] REG_STOP_PAT  = 3'd2;
  localparam logic [2:0] REG_STOP_LEN  = 3'd3;
  localparam logic [2:0] REG_MAX_FIELD = 3'd4;

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_COLLECT,
    PH_DONE
  } phase_t;

  // One unit of work for the back end: a run read from the buffer,
  // or a single status result
  typedef struct packed {
    logic             run;
    logic [1:0]       status;
    logic [LEN_W-1:0] len;
  } job_t;

  // Buffer write from the front end
  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

endpackage
`default_nettype wire

// File: hdl/dfe_front.sv
// Front end: accepts bytes, tracks delimiters, fills the field buffer
// and posts jobs. Depends on dfe_pkg.
`default_nettype none
module dfe_front
  import dfe_pkg::*;
#(
  parameter int MAX_FIELD = 32,
  parameter int MAX_DELIM = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [7:0]       in_char,
  input  wire logic [63:0]      start_pattern,
  input  wire logic [3:0]       start_length,
  input  wire logic [63:0]      stop_pattern,
  input  wire logic [3:0]       stop_length,
  input  wire logic [5:0]       max_field_len,
  input  wire logic             job_full,
  input  wire logic             run_busy,
  output logic                  job_push,
  output job_t                  job,
  output buf_wr_t               buf_wr
);

  localparam int BUF_DEPTH = MAX_FIELD + MAX_DELIM;
  localparam int CC_W      = $clog2(BUF_DEPTH + 1);

  phase_t            phase, phase_next;
  logic [WIN_W-1:0]  window, window_next;
  logic [3:0]        seen, seen_next;
  logic [CC_W-1:0]   cc, cc_next;
  logic              ovf, ovf_next;

  logic              accept;
  logic [WIN_W-1:0]  win_shift;
  logic [3:0]        seen_inc;
  logic [3:0]        start_n, stop_n;
  logic [5:0]        limit;
  logic [CC_W-1:0]   cc_new;
  logic              ovf_new;
  logic [CC_W-1:0]   flen;

  // Clamp a delimiter length to 1..MAX_DELIM
  function automatic logic [3:0] eff_len(input logic [3:0] len);
    logic [3:0] r;
    r = len;
    if (len == 4'd0) r = 4'd1;
    else if (len > 4'(MAX_DELIM)) r = 4'(MAX_DELIM);
    return r;
  endfunction

  // Compare the newest n window bytes against the pattern
  function automatic logic win_match(input logic [WIN_W-1:0] win,
                                     input logic [63:0] pat,
                                     input logic [3:0] n,
                                     input logic [3:0] cnt);
    logic       ok;
    logic [3:0] pos;
    ok = (cnt >= n);
    for (int i = 0; i < 8; i++) begin
      pos = 4'd8 - n + 4'(i);
      if (4'(i) < n && win[{pos[2:0], 3'b000} +: 8] != pat[i*8 +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  assign full      = job_full || (phase == PH_COLLECT && run_busy);
  assign accept    = push && !full;
  assign win_shift = {in_char, window[WIN_W-1:8]};
  assign seen_inc  = (seen < 4'd8) ? seen + 4'd1 : seen;
  assign start_n   = eff_len(start_length);
  assign stop_n    = eff_len(stop_length);
  assign limit     = (max_field_len > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : max_field_len;

  // Next state and job generation
  always_comb begin
    phase_next  = phase;
    window_next = window;
    seen_next   = seen;
    cc_next     = cc;
    ovf_next    = ovf;
    job_push    = 1'b0;
    job         = '0;
    buf_wr      = '0;
    cc_new      = cc;
    ovf_new     = ovf;
    flen        = '0;
    if (accept) begin
      if (in_char == 8'd0) begin
        // End of string: null result unless a result already went out
        if (phase != PH_DONE) begin
          job_push   = 1'b1;
          job.status = ST_NULL;
        end
        phase_next  = PH_SEEK;
        window_next = '0;
        seen_next   = '0;
        cc_next     = '0;
        ovf_next    = 1'b0;
      end else begin
        unique case (phase)
          PH_SEEK: begin
            window_next = win_shift;
            seen_next   = seen_inc;
            if (win_match(win_shift, start_pattern, start_n, seen_inc)) begin
              phase_next = PH_COLLECT;
              seen_next  = '0;
              cc_next    = '0;
              ovf_next   = 1'b0;
            end
          end
          PH_COLLECT: begin
            window_next = win_shift;
            seen_next   = seen_inc;
            // Store the byte, or flag overflow once the buffer is full
            if (cc < CC_W'(BUF_DEPTH)) begin
              buf_wr.en   = 1'b1;
              buf_wr.addr = LEN_W'(cc);
              buf_wr.data = in_char;
              cc_new      = cc + 1'b1;
            end else begin
              ovf_new = 1'b1;
            end
            cc_next  = cc_new;
            ovf_next = ovf_new;
            if (win_match(win_shift, stop_pattern, stop_n, seen_inc)) begin
              phase_next = PH_DONE;
              flen = (cc_new >= CC_W'(stop_n)) ? cc_new - CC_W'(stop_n) : '0;
              job_push = 1'b1;
              if (ovf_new || CMP_W'(flen) > CMP_W'(limit)) begin
                job.status = ST_LONG;
              end else if (flen == '0) begin
                job.status = ST_EMPTY;
              end else begin
                job.run    = 1'b1;
                job.status = ST_BYTE;
                job.len    = LEN_W'(flen);
              end
            end
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SEEK;
      window <= '0;
      seen   <= '0;
      cc     <= '0;
      ovf    <= 1'b0;
    end else begin
      phase  <= phase_next;
      window <= window_next;
      seen   <= seen_next;
      cc     <= cc_next;
      ovf    <= ovf_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/dfe_jobq.sv
// Two-entry job queue between the front and back ends.
// Depends on dfe_pkg.
`default_nettype none
module dfe_jobq
  import dfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      din,
  output logic      full,
  output logic      valid,
  output job_t      dout,
  input  wire logic pop,
  output logic      run_pending
);

  job_t       slots [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       occ0, occ1;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = slots[rptr];

  // Flag any queued run so the front holds off buffer writes
  assign occ0 = (count == 2'd2) || (count == 2'd1 && rptr == 1'b0);
  assign occ1 = (count == 2'd2) || (count == 2'd1 && rptr == 1'b1);
  assign run_pending = (occ0 && slots[0].run) || (occ1 && slots[1].run);

  // Store beats
  always_ff @(posedge clk) begin
    if (push && !full) slots[wptr] <= din;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (pop && valid)  rptr <= ~rptr;
      count <= count + 2'(push && !full) - 2'(pop && valid);
    end
  end

endmodule
`default_nettype wire

// File: hdl/dfe_back.sv
// Back end: field buffer memory, run reader and result queue.
// Depends on dfe_pkg.
`default_nettype none
module dfe_back
  import dfe_pkg::*;
#(
  parameter int MAX_FIELD = 32,
  parameter int MAX_DELIM = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  buf_wr_t         buf_wr,
  input  wire logic       job_valid,
  input  job_t            job,
  output logic            job_pop,
  output logic            active,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic [1:0]      status,
  output logic            last
);

  localparam int BUF_DEPTH = MAX_FIELD + MAX_DELIM;
  localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int OQ_DEPTH  = 4;

  logic [7:0]       mem [BUF_DEPTH];
  logic [7:0]       rd_data;

  logic [LEN_W-1:0] k, len;
  logic             room, issue_rd, run_last;

  logic             s1_valid, s1_mem, s1_last;
  logic [1:0]       s1_status;

  logic [7:0]       q_byte   [OQ_DEPTH];
  logic [1:0]       q_status [OQ_DEPTH];
  logic             q_last   [OQ_DEPTH];
  logic [1:0]       q_wptr, q_rptr;
  logic [2:0]       q_count;
  logic             q_push, q_pop;
  logic [7:0]       q_in_byte;

  // Field buffer: front writes, read one byte a cycle on issue_rd
  always_ff @(posedge clk) begin
    if (buf_wr.en) mem[buf_wr.addr[ADDR_W-1:0]] <= buf_wr.data;
    if (issue_rd) rd_data <= mem[k[ADDR_W-1:0]];
  end

  // Issue only when the result queue can take the beat in flight
  assign room     = (4'(q_count) + 4'(s1_valid)) < 4'(OQ_DEPTH);
  assign issue_rd = active && room;
  assign run_last = (k == len - 1'b1);
  assign job_pop  = !active && job_valid && room;

  // Run sequencer and read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= 1'b0;
      if (issue_rd) begin
        s1_valid <= 1'b1;
        if (run_last) active <= 1'b0;
      end else if (job_pop) begin
        if (job.run) begin
          active <= 1'b1;
        end else begin
          s1_valid <= 1'b1;
        end
      end
    end
  end

  // Payload of the read stage and the read address
  always_ff @(posedge clk) begin
    if (issue_rd) begin
      k         <= k + 1'b1;
      s1_mem    <= 1'b1;
      s1_status <= ST_BYTE;
      s1_last   <= run_last;
    end else if (job_pop) begin
      k         <= '0;
      len       <= job.len;
      s1_mem    <= 1'b0;
      s1_status <= job.status;
      s1_last   <= 1'b1;
    end
  end

  // Result queue
  assign q_push    = s1_valid;
  assign q_pop     = pop && !empty;
  assign q_in_byte = s1_mem ? rd_data : 8'd0;
  assign empty     = (q_count == 3'd0);
  assign out_byte  = q_byte[q_rptr];
  assign status    = q_status[q_rptr];
  assign last      = q_last[q_rptr];

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_byte[q_wptr]   <= q_in_byte;
      q_status[q_wptr] <= s1_status;
      q_last[q_wptr]   <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wptr  <= '0;
      q_rptr  <= '0;
      q_count <= '0;
    end else begin
      if (q_push) q_wptr <= q_wptr + 1'b1;
      if (q_pop)  q_rptr <= q_rptr + 1'b1;
      q_count <= q_count + 3'(q_push) - 3'(q_pop);
    end
  end

endmodule
`default_nettype wire

// File: hdl/delimited_field_extractor_core.sv
// Top level of the delimited field extractor: configuration registers
// and the front, job queue and back ends. Depends on dfe_pkg.
//
//  Channel   Handshake            Beat contents
//  input     push / full          in_char
//  result    pop / empty          out_byte, status, last
//  config    psel/penable/pwrite  paddr (8 bytes a register), pwdata, prdata
//
// The front takes one byte a cycle while full is low. A field of n bytes
// leaves as n result beats, one a cycle while the result queue has room,
// via the job queue, run sequencer, read stage and result queue. full
// rises while the job queue holds two jobs, or while a run is queued or
// read out and the front is collecting a new field. Reset is synchronous,
// clears control state and restores configuration defaults.
`default_nettype none
module delimited_field_extractor_core
  import dfe_pkg::*;
#(
  parameter int MAX_FIELD = 32,
  parameter int MAX_DELIM = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_char,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic [1:0]       status,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] start_pattern, stop_pattern;
  logic [3:0]  start_length, stop_length;
  logic [5:0]  max_field_len;
  logic        cfg_we;
  logic [2:0]  reg_idx;

  job_t    fr_job, q_job;
  logic    fr_push, q_full, q_valid, q_pop, run_pending, back_active;
  buf_wr_t buf_wr;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pattern <= '0;
      start_length  <= 4'd1;
      stop_pattern  <= '0;
      stop_length   <= 4'd1;
      max_field_len <= 6'd30;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_START_PAT: start_pattern <= pwdata;
        REG_START_LEN: start_length  <= pwdata[3:0];
        REG_STOP_PAT:  stop_pattern  <= pwdata;
        REG_STOP_LEN:  stop_length   <= pwdata[3:0];
        REG_MAX_FIELD: max_field_len <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    unique case (reg_idx)
      REG_START_PAT: prdata = start_pattern;
      REG_START_LEN: prdata = 64'(start_length);
      REG_STOP_PAT:  prdata = stop_pattern;
      REG_STOP_LEN:  prdata = 64'(stop_length);
      REG_MAX_FIELD: prdata = 64'(max_field_len);
      default:       prdata = '0;
    endcase
  end

  dfe_front #(
    .MAX_FIELD(MAX_FIELD),
    .MAX_DELIM(MAX_DELIM)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .in_char       (in_char),
    .start_pattern (start_pattern),
    .start_length  (start_length),
    .stop_pattern  (stop_pattern),
    .stop_length   (stop_length),
    .max_field_len (max_field_len),
    .job_full      (q_full),
    .run_busy      (run_pending || back_active),
    .job_push      (fr_push),
    .job           (fr_job),
    .buf_wr        (buf_wr)
  );

  dfe_jobq u_jobq (
    .clk         (clk),
    .rst         (rst),
    .push        (fr_push),
    .din         (fr_job),
    .full        (q_full),
    .valid       (q_valid),
    .dout        (q_job),
    .pop         (q_pop),
    .run_pending (run_pending)
  );

  dfe_back #(
    .MAX_FIELD(MAX_FIELD),
    .MAX_DELIM(MAX_DELIM)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .buf_wr    (buf_wr),
    .job_valid (q_valid),
    .job       (q_job),
    .job_pop   (q_pop),
    .active    (back_active),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
  );

endmodule
`default_nettype wire

// File: sim/dfe_checker.sv
// Checker for the delimited field extractor: watches the input, result and
// register channels, predicts result beats and compares them in order.
// Depends on dfe_pkg for phase, status and register index codes.
module dfe_checker
  import dfe_pkg::*;
#(
  parameter int MAX_FIELD = 32,
  parameter int MAX_DELIM = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_char,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic [1:0]  status,
  input  logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output int          errors,
  output int          pending
);

  localparam int BUF_DEPTH = MAX_FIELD + MAX_DELIM;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] code;
    logic       fin;
  } beat_t;

  beat_t field_q[$];

  // Shadow copy of the registers
  logic [63:0] start_pat, stop_pat;
  logic [3:0]  start_len, stop_len;
  logic [5:0]  max_len;

  // Shadow copy of the string state
  logic [63:0] window;
  phase_t      phase;
  int unsigned seen;
  int unsigned count;
  logic [7:0]  field_buf [BUF_DEPTH];
  logic        overflow;
  int          fail_count = 0;

  function automatic int unsigned delim_len(logic [3:0] len);
    if (len == 4'd0) return 1;
    if (len > MAX_DELIM) return MAX_DELIM;
    return 32'(len);
  endfunction

  // Compare the newest bytes of the window with a delimiter
  function automatic logic tail_matches(logic [63:0] pat, logic [3:0] len);
    int unsigned n;
    logic [63:0] mask;
    logic [63:0] tail;
    n = delim_len(len);
    mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    tail = window >> (64 - 8 * n);
    if (seen < n) return 1'b0;
    return ((tail ^ pat) & mask) == 64'd0;
  endfunction

  task automatic clear_string();
    window = '0;
    phase = PH_SEEK;
    seen = 0;
    count = 0;
    overflow = 1'b0;
  endtask

  task automatic expect_single(logic [1:0] code);
    field_q.push_back(beat_t'{8'd0, code, 1'b1});
  endtask

  // Advance the predicted state by one accepted character
  task automatic extract_char(logic [7:0] c);
    int unsigned lim, slen, flen;
    logic was_done;
    if (c == 8'd0) begin
      was_done = (phase == PH_DONE);
      clear_string();
      if (!was_done) expect_single(ST_NULL);
      return;
    end
    if (phase == PH_DONE) return;
    window = {c, window[63:8]};
    if (seen < 8) seen++;
    if (phase == PH_SEEK) begin
      if (tail_matches(start_pat, start_len)) begin
        phase = PH_COLLECT;
        seen = 0;
        count = 0;
        overflow = 1'b0;
      end
      return;
    end
    if (count < BUF_DEPTH) begin
      field_buf[count] = c;
      count++;
    end else begin
      overflow = 1'b1;
    end
    if (tail_matches(stop_pat, stop_len)) begin
      lim = (max_len > MAX_FIELD) ? MAX_FIELD : 32'(max_len);
      slen = delim_len(stop_len);
      flen = (count >= slen) ? count - slen : 0;
      phase = PH_DONE;
      if (overflow || flen > lim) expect_single(ST_LONG);
      else if (flen == 0) expect_single(ST_EMPTY);
      else begin
        for (int k = 0; k < flen; k++)
          field_q.push_back(beat_t'{field_buf[k], ST_BYTE, (k + 1 == flen)});
      end
    end
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (rst) begin
      start_pat = '0;
      start_len = 4'd1;
      stop_pat = '0;
      stop_len = 4'd1;
      max_len = 6'd30;
      clear_string();
      field_q.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_START_PAT: start_pat = pwdata;
          REG_START_LEN: start_len = pwdata[3:0];
          REG_STOP_PAT:  stop_pat = pwdata;
          REG_STOP_LEN:  stop_len = pwdata[3:0];
          REG_MAX_FIELD: max_len = pwdata[5:0];
          default: ;
        endcase
      end
      if (push && !full) extract_char(in_char);
      // Check each result beat against the oldest prediction
      if (pop && !empty) begin
        if (field_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: byte=%h status=%0d last=%b",
                     out_byte, status, last);
        end else begin
          want = field_q.pop_front();
          if (out_byte !== want.data || status !== want.code || last !== want.fin) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp byte=%h status=%0d last=%b, got byte=%h status=%0d last=%b",
                       want.data, want.code, want.fin, out_byte, status, last);
          end
        end
      end
    end
    pending <= field_q.size();
    errors <= fail_count;
  end

endmodule

// File: sim/testbench.sv
// Testbench top for delimited_field_extractor_core: clock, reset, register
// setup, character strings and result pops; the verdict comes from dfe_checker.
// Depends on dfe_pkg, delimited_field_extractor_core and dfe_checker.
module testbench
  import dfe_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  in_char = 8'd0;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = 6'd0;
  logic [63:0] pwdata = 64'd0;

  wire         full, empty, last, pready;
  wire [7:0]   out_byte;
  wire [1:0]   status;
  wire [63:0]  prdata;
  int          errors, pending;

  int          send_idle_pct = 32;
  int          recv_idle_pct = 57;
  int          random_items = 0;
  logic [7:0]  line_q[$];

  // Register values as last written, used to shape the strings
  logic [63:0] gen_start_pat = 64'd0;
  logic [63:0] gen_stop_pat = 64'd0;
  logic [3:0]  gen_start_len = 4'd1;
  logic [3:0]  gen_stop_len = 4'd1;
  logic [5:0]  gen_max_len = 6'd30;

  always #10 clk = ~clk;

  delimited_field_extractor_core u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_char(in_char),
    .empty(empty), .pop(pop), .out_byte(out_byte), .status(status), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dfe_checker u_check (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_char(in_char),
    .empty(empty), .pop(pop), .out_byte(out_byte), .status(status), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending)
  );

  // Stall the result side at random
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hold off between beats at random, then present one character
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_char <= c;
    do @(posedge clk); while (full);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
    line_q.delete();
  endtask

  // Leave psel up at the end so back-to-back writes need one assignment a step
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(input logic [63:0] s_pat, input logic [3:0] s_len,
                           input logic [63:0] e_pat, input logic [3:0] e_len,
                           input logic [5:0] f_max);
    gen_start_pat = s_pat;
    gen_start_len = s_len;
    gen_stop_pat = e_pat;
    gen_stop_len = e_len;
    gen_max_len = f_max;
    write_reg(REG_START_PAT, s_pat);
    write_reg(REG_START_LEN, {60'd0, s_len});
    write_reg(REG_STOP_PAT, e_pat);
    write_reg(REG_STOP_LEN, {60'd0, e_len});
    write_reg(REG_MAX_FIELD, {58'd0, f_max});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop push, wait for every predicted beat, then let the pipeline empty
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  function automatic int unsigned clip_len(logic [3:0] len);
    if (len == 4'd0) return 1;
    return (len > 4'd8) ? 8 : 32'(len);
  endfunction

  function automatic logic [63:0] rand_pattern();
    logic [63:0] pat;
    for (int i = 0; i < 8; i++) pat[8*i +: 8] = 8'($urandom_range(1, 255));
    return pat;
  endfunction

  // Noise leans on delimiter bytes so partial and stray matches show up
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1:    c = gen_start_pat[8 * $urandom_range(clip_len(gen_start_len) - 1) +: 8];
      2, 3:    c = gen_stop_pat[8 * $urandom_range(clip_len(gen_stop_len) - 1) +: 8];
      default: c = 8'($urandom_range(1, 255));
    endcase
    if (c == 8'd0) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  // Mostly well-formed strings; some lack a delimiter or are empty
  task automatic build_line();
    int unsigned roll, flen, lim;
    roll = $urandom_range(99);
    lim = (gen_max_len > 6'd32) ? 32 : 32'(gen_max_len);
    line_q.delete();
    if (roll >= 5) begin
      repeat ($urandom_range(0, 4)) line_q.push_back(pick_char());
      if (roll >= 13) begin
        for (int i = 0; i < clip_len(gen_start_len); i++)
          line_q.push_back(gen_start_pat[8*i +: 8]);
      end
      flen = ($urandom_range(99) < 85) ? $urandom_range(0, lim + 2) : $urandom_range(0, 44);
      repeat (flen) line_q.push_back(pick_char());
      if (roll >= 28) begin
        for (int i = 0; i < clip_len(gen_stop_len); i++)
          line_q.push_back(gen_stop_pat[8*i +: 8]);
      end
    end
    random_items += line_q.size() + 1;
    // Tail after the stop delimiter is skipped by the block
    repeat ($urandom_range(0, 3)) line_q.push_back(pick_char());
    line_q.push_back(8'd0);
  endtask

  initial begin
    logic [63:0] s_pat, e_pat;
    logic [3:0]  s_len, e_len;
    logic [5:0]  f_max;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset delimiters hold a zero byte, so nothing can match
    line_q = {8'hFF, 8'h01, 8'h00};
    send_line();
    settle();

    // Start length zero acts as one; limit above the maximum is clipped
    configure(64'h5B, 4'd0, 64'h5D, 4'd1, 6'd40);
    line_q = {8'h5B, 8'h5D, 8'h00};
    send_line();
    line_q = {8'h5B, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'h5D, 8'h7A, 8'h00};
    send_line();
    line_q = {8'h5B, 8'h71, 8'h00};
    send_line();
    settle();

    // Stop may not overlap start; zero limit makes any byte too long
    configure(64'h6161, 4'd2, 64'h6261, 4'd2, 6'd0);
    line_q = {8'h61, 8'h61, 8'h61, 8'h62, 8'h00};
    send_line();
    line_q = {8'h61, 8'h61, 8'h63, 8'h61, 8'h62, 8'h00};
    send_line();

    random_items = 0;
    for (int p = 0; p < 6; p++) begin
      settle();
      s_pat = rand_pattern();
      e_pat = rand_pattern();
      s_len = 4'($urandom_range(1, 8));
      e_len = 4'($urandom_range(1, 8));
      f_max = 6'($urandom_range(0, 40));
      case (p)
        0: begin s_len = 4'd1; e_len = 4'd8; f_max = 6'd32; end
        1: begin s_len = 4'd8; e_len = 4'd1; f_max = 6'd0; end
        2: begin s_len = 4'd15; e_len = 4'd0; f_max = 6'd63; end
        4: e_pat[8 * $urandom_range(clip_len(e_len) - 1) +: 8] = 8'd0;
        default: ;
      endcase
      configure(s_pat, s_len, e_pat, e_len, f_max);
      while (random_items < (p + 1) * 80) begin
        if (random_items < 160) begin
          send_idle_pct = 32;
          recv_idle_pct = 57;
        end else if (random_items < 320) begin
          send_idle_pct = 57;
          recv_idle_pct = 32;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        build_line();
        send_line();
      end
    end
    settle();

    if (errors == 0 && pending == 0)
      $display("delimited_field_extractor_core test passed");
    else
      $display("delimited_field_extractor_core test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("delimited_field_extractor_core test failed");
    $finish;
  end

endmodule
